// ===== hw/rtl/pcld_pkg.sv =====
// Shared types, constants and reason codes for the prologue cut-length decoder.
// Used by the lane decoder, the boundary walker and the top level.
`default_nettype none
package pcld_pkg;

    localparam int IN_BYTES     = 16;
    localparam int WINDOW_BYTES = 16;
    localparam int NEED_MAX     = 12;
    localparam int LANES        = NEED_MAX;
    localparam int LANE_IDX_W   = $clog2(LANES);
    localparam int LEN_W        = 4;
    localparam int CUT_W        = 5;
    localparam int REASON_W     = 4;
    localparam int MIN_CUT_W    = 4;
    localparam int OUT_DATA_W   = 16;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [0:0] REG_MIN_CUT = 1'b0;
    localparam logic [MIN_CUT_W-1:0] MIN_CUT_RESET = 4'd12;

    localparam logic [REASON_W-1:0] REASON_OK           = 4'd0;
    localparam logic [REASON_W-1:0] REASON_REL_CALL_JMP = 4'd1;
    localparam logic [REASON_W-1:0] REASON_JMP_REL8     = 4'd2;
    localparam logic [REASON_W-1:0] REASON_JCC_REL8     = 4'd3;
    localparam logic [REASON_W-1:0] REASON_JCC_REL32    = 4'd4;
    localparam logic [REASON_W-1:0] REASON_MOV_RSP      = 4'd5;
    localparam logic [REASON_W-1:0] REASON_LEA_RIP      = 4'd6;
    localparam logic [REASON_W-1:0] REASON_RIP_MEM      = 4'd7;
    localparam logic [REASON_W-1:0] REASON_UNKNOWN      = 4'd8;

    typedef struct packed {
        logic [REASON_W-1:0] reason;
        logic [LEN_W-1:0]    len;
    } lane_res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pcld_lane.sv =====
// One lane: decodes the instruction that starts at a fixed offset of the window.
// Depends on pcld_pkg for the reason codes and the lane result type.
`default_nettype none
module pcld_lane (
    input  wire logic [7:0]         b0,
    input  wire logic [7:0]         b1,
    input  wire logic [7:0]         b2,
    output pcld_pkg::lane_res_t     res
);
    import pcld_pkg::*;

    logic       rex;
    logic [7:0] op;
    logic [7:0] m;
    logic [7:0] mm;
    logic [3:0] mlen;

    assign rex = (b0[7:4] == 4'h4);
    assign op  = rex ? b1 : b0;
    assign m   = rex ? b2 : b1;
    assign mm  = m & 8'hC7;

    always_comb begin
        mlen = 4'd2 + {3'd0, (m[2:0] == 3'd4)};
        if (m[7:6] == 2'd1) begin
            mlen = mlen + 4'd1;
        end else if (m[7:6] == 2'd2) begin
            mlen = mlen + 4'd4;
        end
    end

    always_comb begin
        res.reason = REASON_OK;
        res.len    = '0;
        if (op == 8'hE8 || op == 8'hE9) begin
            res.reason = REASON_REL_CALL_JMP;
        end else if (op == 8'hEB) begin
            res.reason = REASON_JMP_REL8;
        end else if (op[7:4] == 4'h7) begin
            res.reason = REASON_JCC_REL8;
        end else if (op == 8'h0F && m[7:4] == 4'h8) begin
            res.reason = REASON_JCC_REL32;
        end else if (rex && op == 8'h8B && mm == 8'hC4) begin
            res.reason = REASON_MOV_RSP;
        end else if (rex && op == 8'h8D && mm == 8'h05) begin
            res.reason = REASON_LEA_RIP;
        end else if ((op == 8'h89 || op == 8'h8B) && mm == 8'h05) begin
            res.reason = REASON_RIP_MEM;
        end else if (op[7:3] == 5'b01010) begin
            res.len = 4'd1 + {3'd0, rex};
        end else if (op == 8'h89 || op == 8'h8B) begin
            res.len = mlen + {3'd0, rex};
        end else if (op == 8'h83) begin
            res.len = 4'd3 + {3'd0, rex};
        end else if (op == 8'h81) begin
            res.len = 4'd6 + {3'd0, rex};
        end else if (op == 8'hC7) begin
            res.len = mlen + 4'd4 + {3'd0, rex};
        end else begin
            res.reason = REASON_UNKNOWN;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/pcld_walker.sv =====
// Merging stage: holds the lane results of one beat and walks the boundaries,
// one instruction per cycle, into the output register. Depends on pcld_pkg.
`default_nettype none
module pcld_walker (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    start,
    input  wire logic [pcld_pkg::MIN_CUT_W-1:0]          need_in,
    input  wire pcld_pkg::lane_res_t [pcld_pkg::LANES-1:0] lane_in,
    output logic                                         in_ready,
    output logic                                         out_valid,
    input  wire logic                                    out_ready,
    output logic [pcld_pkg::CUT_W-1:0]                   out_cut,
    output logic [pcld_pkg::REASON_W-1:0]                out_reason
);
    import pcld_pkg::*;

    lane_res_t [LANES-1:0]  lanes_reg;
    logic [MIN_CUT_W-1:0]   need_reg;
    logic [CUT_W-1:0]       pos_reg;
    logic [CUT_W-1:0]       pos_next;
    logic                   busy_reg;
    logic                   out_valid_reg;
    logic [CUT_W-1:0]       cut_reg;
    logic [REASON_W-1:0]    reason_reg;
    lane_res_t              cur;
    logic                   done;
    logic                   out_free;

    assign cur      = lanes_reg[pos_reg[LANE_IDX_W-1:0]];
    assign pos_next = pos_reg + {{(CUT_W-LEN_W){1'b0}}, cur.len};
    assign done     = (cur.reason != REASON_OK) ||
                      (pos_next >= {{(CUT_W-MIN_CUT_W){1'b0}}, need_reg});
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end else begin
            if (busy_reg && done && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (busy_reg) begin
                if (done) begin
                    if (out_free) begin
                        busy_reg <= 1'b0;
                    end
                end else begin
                    pos_reg <= pos_next;
                end
            end else if (start) begin
                busy_reg <= 1'b1;
                pos_reg  <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!busy_reg && start) begin
            lanes_reg <= lane_in;
            need_reg  <= need_in;
        end
        if (busy_reg && done && out_free) begin
            reason_reg <= cur.reason;
            cut_reg    <= (cur.reason != REASON_OK) ? '0 : pos_next;
        end
    end

    assign in_ready   = !busy_reg;
    assign out_valid  = out_valid_reg;
    assign out_cut    = cut_reg;
    assign out_reason = reason_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/prologue_cut_length_decoder_top.sv =====
// Top level of the prologue cut-length decoder: stream ports, APB register,
// one lane decoder per start offset and the boundary walker. Depends on pcld_pkg.
//
// Each input beat carries the first sixteen bytes of a function prologue. Twelve
// lane decoders size the instruction at each start offset from 0 to 11 in the cycle
// the beat is taken; the walker then follows the boundaries one instruction per
// cycle. The walker takes no new beat until it has handed the result of the last
// one over, which it does only once the output register is free or being emptied,
// and the register holds it until the downstream side takes it. The minimum cut
// length register is decoded at byte addresses 0 to 3; a value of 0 acts as 1 and
// values above 12 act as 12.
`default_nettype none
module prologue_cut_length_decoder_top #(
    parameter int WINDOW_BYTES = pcld_pkg::WINDOW_BYTES
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // bytes_low [63:0], bytes_high [127:64]
    input  wire logic [8*pcld_pkg::IN_BYTES-1:0]    s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // cut_length [4:0], refuse_reason [8:5], zero [15:9]
    output logic [pcld_pkg::OUT_DATA_W-1:0]         m_tdata,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [pcld_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [pcld_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [pcld_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                    pready
);
    import pcld_pkg::*;

    logic [MIN_CUT_W-1:0]    min_cut_reg;
    logic [MIN_CUT_W-1:0]    need;
    lane_res_t [LANES-1:0]   lane_res;
    logic [CUT_W-1:0]        cut;
    logic [REASON_W-1:0]     reason;
    logic                    reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_ADDR_W-1] == REG_MIN_CUT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_cut_reg <= MIN_CUT_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            min_cut_reg <= pwdata[MIN_CUT_W-1:0];
        end
    end

    assign prdata = reg_sel ? {{(APB_DATA_W-MIN_CUT_W){1'b0}}, min_cut_reg} : '0;

    always_comb begin
        need = min_cut_reg;
        if (min_cut_reg == '0) begin
            need = MIN_CUT_W'(1);
        end else if (min_cut_reg > MIN_CUT_W'(NEED_MAX)) begin
            need = MIN_CUT_W'(NEED_MAX);
        end
    end

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        logic [7:0] win [3];
        for (genvar j = 0; j < 3; j++) begin : g_byte
            localparam int Idx = k + j;
            if (Idx < WINDOW_BYTES && Idx < IN_BYTES) begin : g_in
                assign win[j] = s_tdata[8*Idx +: 8];
            end else begin : g_zero
                assign win[j] = 8'h00;
            end
        end
        pcld_lane u_lane (
            .b0  (win[0]),
            .b1  (win[1]),
            .b2  (win[2]),
            .res (lane_res[k])
        );
    end

    pcld_walker u_walker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (s_tvalid && s_tready),
        .need_in    (need),
        .lane_in    (lane_res),
        .in_ready   (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_cut    (cut),
        .out_reason (reason)
    );

    assign m_tdata = {{(OUT_DATA_W-CUT_W-REASON_W){1'b0}}, reason, cut};

endmodule
`default_nettype wire

// ===== hw/rtl/pcld_checker.sv =====
// Port-level checks for the prologue cut-length decoder, bound to the top level.
// Sees the top level's ports only; has no other dependency.
`default_nettype none
module pcld_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [15:0]  m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_cut_xor_refuse: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[4:0] == 5'd0) != (m_tdata[8:5] == 4'd0)))
        else $error("cut length and refusal reason disagree");

    a_ranges: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[8:5] <= 4'd8) && (m_tdata[4:0] <= 5'd23)
                     && (m_tdata[15:9] == 7'd0))
        else $error("result beat out of range");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat taken while a walk is under way");

endmodule

bind prologue_cut_length_decoder_top pcld_checker u_pcld_checker (.*);
`default_nettype wire
